[design/rie_pkg.sv]
// ----------------------------------------------------------------------------
// rie_pkg
// shared types and constants of the run-length image expander
// ----------------------------------------------------------------------------
package rie_pkg;

   localparam int HEADER_BYTES_DEFAULT = 10;
   localparam int PIXELS_PER_RESULT    = 4;
   localparam int RUN_WIDTH            = 8;
   localparam int LEFT_WIDTH           = 33;

   localparam logic [1:0] FMT_VALUE8   = 2'd0;
   localparam logic [1:0] FMT_RGBA5551 = 2'd1;
   localparam logic [1:0] FMT_RGBA32   = 2'd2;

   localparam logic REG_PIXEL_FORMAT = 1'b0;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_0;
      logic [31:0] pixel_1;
      logic [31:0] pixel_2;
      logic [31:0] pixel_3;
      logic [2:0]  pixel_count;
      logic        run_last;
      logic        image_done;
   } rsp_type;

   typedef struct packed {
      logic                 load;
      logic [31:0]          pix;
      logic [RUN_WIDTH-1:0] length;
      logic                 done;
   } run_type;

endpackage

[design/rie_parser.sv]
// ----------------------------------------------------------------------------
// rie_parser
// header and record parser, turns accepted stream bytes into runs
// ----------------------------------------------------------------------------
module rie_parser #(
   parameter int HEADER_BYTES = rie_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  rie_pkg::req_type req,
   input  logic [1:0]       pixel_format,
   output rie_pkg::run_type run
);
   import rie_pkg::*;

   localparam int PW = $clog2(HEADER_BYTES);
   localparam logic [PW-1:0] HDR_END = PW'(HEADER_BYTES - 1);

   logic [PW-1:0]         phase_ff, phase_in, phase_c;
   logic                  in_header_ff, in_header_in, in_header_c;
   logic [15:0]           width_ff, width_in, width_c;
   logic [15:0]           height_ff, height_in, height_c;
   logic [LEFT_WIDTH-1:0] left_ff, left_in, left_c, left_dec;
   logic [RUN_WIDTH-1:0]  rl_ff, rl_in, rl_c;
   logic [7:0]            red_ff, red_in, red_c;
   logic [7:0]            green_ff, green_in, green_c;
   logic                  fin_ff, fin_in, fin_c;
   logic [15:0]           height_hdr;
   logic [31:0]           area;
   logic [7:0]            b;
   logic                  emit;
   logic [31:0]           pix;
   logic [RUN_WIDTH-1:0]  n;

   assign b          = req.stream_byte;
   // height low byte may arrive on the last header byte of a short header
   assign height_hdr = (phase_c == PW'(3)) ? {height_c[15:8], b} : height_c;
   assign area       = width_c * height_hdr;
   assign left_dec   = left_c - LEFT_WIDTH'(rl_c);

   always_comb begin
      if (req.frame_start) begin
         phase_c     = '0;
         in_header_c = 1'b1;
         width_c     = '0;
         height_c    = '0;
         left_c      = '0;
         rl_c        = '0;
         red_c       = '0;
         green_c     = '0;
         fin_c       = 1'b0;
      end else begin
         phase_c     = phase_ff;
         in_header_c = in_header_ff;
         width_c     = width_ff;
         height_c    = height_ff;
         left_c      = left_ff;
         rl_c        = rl_ff;
         red_c       = red_ff;
         green_c     = green_ff;
         fin_c       = fin_ff;
      end
   end

   always_comb begin
      phase_in     = phase_c;
      in_header_in = in_header_c;
      width_in     = width_c;
      height_in    = height_c;
      left_in      = left_c;
      rl_in        = rl_c;
      red_in       = red_c;
      green_in     = green_c;
      fin_in       = fin_c;
      emit         = 1'b0;
      pix          = {24'd0, b};
      n            = rl_c;
      if (fin_c) begin
         emit = 1'b0;
      end else if (in_header_c) begin
         if (phase_c == PW'(0)) width_in  = {b, width_c[7:0]};
         if (phase_c == PW'(1)) width_in  = {width_c[15:8], b};
         if (phase_c == PW'(2)) height_in = {b, height_c[7:0]};
         if (phase_c == PW'(3)) height_in = {height_c[15:8], b};
         phase_in = phase_c + PW'(1);
         if (phase_c == HDR_END) begin
            in_header_in = 1'b0;
            phase_in     = '0;
            left_in      = LEFT_WIDTH'(area);
            if (pixel_format == FMT_VALUE8 && area == 32'd0) fin_in = 1'b1;
         end
      end else if (phase_c == PW'(0)) begin
         rl_in    = b;
         phase_in = PW'(1);
      end else if (pixel_format != FMT_VALUE8 && phase_c == PW'(1)) begin
         red_in   = b;
         phase_in = PW'(2);
      end else if (pixel_format != FMT_VALUE8 && phase_c == PW'(2)) begin
         green_in = b;
         phase_in = PW'(3);
      end else begin
         if (pixel_format == FMT_VALUE8) begin
            pix = {24'd0, b};
            n   = rl_c;
         end else begin
            if (pixel_format == FMT_RGBA5551) begin
               pix = {16'd0, b[7:3], green_c[7:3], red_c[7:3], 1'b1};
            end else begin
               pix = {8'hFF, red_c, green_c, b};
            end
            n = (rl_c != '0) ? rl_c : RUN_WIDTH'(1);
         end
         phase_in = '0;
         left_in  = left_dec;
         if (left_dec[LEFT_WIDTH-1] || left_dec == '0) fin_in = 1'b1;
         emit = (n != '0);
      end
   end

   assign run.load   = accept && emit;
   assign run.pix    = pix;
   assign run.length = n;
   assign run.done   = fin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         in_header_ff <= 1'b1;
         width_ff     <= '0;
         height_ff    <= '0;
         left_ff      <= '0;
         rl_ff        <= '0;
         red_ff       <= '0;
         green_ff     <= '0;
         fin_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         in_header_ff <= in_header_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         left_ff      <= left_in;
         rl_ff        <= rl_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         fin_ff       <= fin_in;
      end
   end

endmodule

[design/rie_expander.sv]
// ----------------------------------------------------------------------------
// rie_expander
// run register that splits a run into pixel groups, and the result register
// ----------------------------------------------------------------------------
module rie_expander (
   input  logic             clock,
   input  logic             reset,
   input  rie_pkg::run_type run,
   output logic             busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rie_pkg::rsp_type rsp_data
);
   import rie_pkg::*;

   logic                 active_ff, active_in;
   logic [31:0]          pix_ff;
   logic [RUN_WIDTH-1:0] left_ff, left_in, rem;
   logic                 done_ff;
   logic                 valid_ff, valid_in;
   rsp_type              data_ff, data_in;
   logic                 out_load;
   logic [2:0]           take;

   assign out_load = !valid_ff || !rsp_stall;
   assign take     = (left_ff > RUN_WIDTH'(PIXELS_PER_RESULT)) ? 3'(PIXELS_PER_RESULT)
                                                               : left_ff[2:0];
   assign rem      = left_ff - RUN_WIDTH'(take);
   assign busy     = active_ff && !(out_load && rem == '0);

   always_comb begin
      active_in = active_ff;
      left_in   = left_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      if (out_load) begin
         valid_in = active_ff;
         if (active_ff) begin
            data_in.pixel_0     = (take > 3'd0) ? pix_ff : 32'd0;
            data_in.pixel_1     = (take > 3'd1) ? pix_ff : 32'd0;
            data_in.pixel_2     = (take > 3'd2) ? pix_ff : 32'd0;
            data_in.pixel_3     = (take > 3'd3) ? pix_ff : 32'd0;
            data_in.pixel_count = take;
            data_in.run_last    = (rem == '0);
            data_in.image_done  = (rem == '0) && done_ff;
            left_in             = rem;
            active_in           = (rem != '0);
         end
      end
      if (run.load) begin
         active_in = 1'b1;
         left_in   = run.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      data_ff <= data_in;
      if (run.load) begin
         pix_ff  <= run.pix;
         done_ff <= run.done;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[design/rle_image_expand_unit.sv]
// ----------------------------------------------------------------------------
// rle_image_expand_unit
// run-length image decoder producing groups of up to four pixels
// ----------------------------------------------------------------------------
// req_* carries one compressed byte per transfer; frame_start marks the first
// header byte of a new image. rsp_* carries a group of up to four identical
// pixels with count, run_last and image_done. pixel_format is written over the
// apb-style port at address 0, by the user only while the block is idle; the
// block itself does not enforce it. header bytes and record bytes that do not
// close a record are taken one per cycle. the byte that closes a record loads
// the run register; the result register then sends one group per cycle unless
// stalled, ceil(n/4) groups for a run of n pixels, and the next byte is taken
// in the cycle the last group moves on. a run's first group passes the run
// register, then the result register. a stalled receiver holds the result
// register; the run register keeps its group until then and req_stall stays
// high while a run is pending. reset clears the parser (header expected), the
// run and the result valid, and sets pixel_format to the eight-bit mode.
// ----------------------------------------------------------------------------
module rle_image_expand_unit #(
   parameter int HEADER_BYTES = rie_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rie_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import rie_pkg::*;

   logic [1:0] fmt_ff;
   logic       accept;
   logic       busy;
   run_type    run;

   assign pready    = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_VALUE8;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_FORMAT) begin
         fmt_ff <= pwdata[1:0];
      end
   end

   assign prdata = (paddr[2] == REG_PIXEL_FORMAT) ? {30'd0, fmt_ff} : 32'd0;

   rie_parser #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .pixel_format(fmt_ff),
      .run         (run)
   );

   rie_expander u_expander (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   a_done_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.image_done |-> rsp_data.run_last)
      else $error("image_done without run_last");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pixel_count != 3'd0 && rsp_data.pixel_count <= 3'd4)
      else $error("pixel_count out of range");

   a_unused_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pixel_count < 3'd4 |-> rsp_data.pixel_3 == 32'd0)
      else $error("unused pixel field not zero");

   a_short_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pixel_count < 3'd4 |-> rsp_data.run_last)
      else $error("partial group not last of run");

endmodule
